FILE: sv/fau_pkg.sv
// ----------------------------------------------------------------------------
// fau_pkg
// types, opcodes and controller states shared by the fraction arithmetic unit
// ----------------------------------------------------------------------------
package fau_pkg;

	localparam int unsigned FIELD_W = 32;
	localparam int unsigned WIDE_W  = 64;

	typedef enum logic [2:0] {
		FUNC_ADD    = 3'd0,
		FUNC_MUL    = 3'd1,
		FUNC_CMP    = 3'd2,
		FUNC_REDUCE = 3'd3,
		FUNC_INVERT = 3'd4
	} func_code_t;

	typedef struct packed {
		logic [2:0]          func;
		logic [FIELD_W-1:0]  num_a;
		logic [FIELD_W-1:0]  den_a;
		logic [FIELD_W-1:0]  num_b;
		logic [FIELD_W-1:0]  den_b;
	} fau_in_t;

	typedef struct packed {
		logic [WIDE_W-1:0] res_num;
		logic [WIDE_W-1:0] res_den;
		logic [1:0]        order;
		logic              status;
	} fau_out_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_FINISH,
		ST_GCD_PRE,
		ST_GCD_SHIFT,
		ST_GCD_ODDU,
		ST_GCD_LOOP,
		ST_DIV_NUM,
		ST_DIV_DEN,
		ST_DONE
	} fau_state_t;

	// command from controller to datapath
	typedef struct packed {
		logic load;
		logic mul1;
		logic mul2;
		logic finish;
		logic gcd_pre;
		logic gcd_shift;
		logic gcd_oddu;
		logic gcd_loop;
		logic div_start_num;
		logic div_step;
		logic done;
	} fau_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic [2:0] func;
		logic       err;
		logic       gcd_trivial;
		logic       both_even;
		logic       u_even;
		logic       v_zero_next;
		logic       div_last;
	} fau_stat_t;

endpackage

FILE: sv/fau_ctrl.sv
// ----------------------------------------------------------------------------
// fau_ctrl
// sequencer: multiply steps, binary gcd loop and the two serial divisions
// ----------------------------------------------------------------------------
module fau_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  fau_pkg::fau_stat_t stat,
	output fau_pkg::fau_cmd_t  cmd,
	output logic               busy
);

	fau_pkg::fau_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= fau_pkg::ST_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = (state_q != fau_pkg::ST_IDLE);
		unique case (state_q)
			fau_pkg::ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = fau_pkg::ST_MUL1;
				end
			end
			fau_pkg::ST_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = fau_pkg::ST_MUL2;
			end
			fau_pkg::ST_MUL2: begin
				cmd.mul2 = 1'b1;
				if (stat.func == fau_pkg::FUNC_REDUCE && !stat.err)
					state_d = fau_pkg::ST_GCD_PRE;
				else
					state_d = fau_pkg::ST_FINISH;
			end
			fau_pkg::ST_FINISH: begin
				cmd.finish = 1'b1;
				state_d    = fau_pkg::ST_DONE;
			end
			fau_pkg::ST_GCD_PRE: begin
				cmd.gcd_pre = 1'b1;
				state_d = stat.gcd_trivial ? fau_pkg::ST_DIV_NUM : fau_pkg::ST_GCD_SHIFT;
			end
			fau_pkg::ST_GCD_SHIFT: begin
				if (stat.both_even) cmd.gcd_shift = 1'b1;
				else                state_d = fau_pkg::ST_GCD_ODDU;
			end
			fau_pkg::ST_GCD_ODDU: begin
				if (stat.u_even) cmd.gcd_oddu = 1'b1;
				else             state_d = fau_pkg::ST_GCD_LOOP;
			end
			fau_pkg::ST_GCD_LOOP: begin
				cmd.gcd_loop = 1'b1;
				if (stat.v_zero_next) state_d = fau_pkg::ST_DIV_NUM;
			end
			fau_pkg::ST_DIV_NUM: begin
				cmd.div_start_num = 1'b1;
				state_d = fau_pkg::ST_DIV_DEN;
			end
			fau_pkg::ST_DIV_DEN: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) state_d = fau_pkg::ST_FINISH;
			end
			fau_pkg::ST_DONE: begin
				cmd.done = 1'b1;
				state_d  = fau_pkg::ST_IDLE;
			end
			default: state_d = fau_pkg::ST_IDLE;
		endcase
	end

endmodule

FILE: sv/fau_dp.sv
// ----------------------------------------------------------------------------
// fau_dp
// operand registers, shared multiplier, binary gcd and restoring divider
// ----------------------------------------------------------------------------
module fau_dp #(
	parameter int unsigned VALUE_WIDTH = 32
) (
	input  logic               clk,
	input  fau_pkg::fau_in_t   in_item,
	input  fau_pkg::fau_cmd_t  cmd,
	output fau_pkg::fau_stat_t stat,
	output fau_pkg::fau_out_t  out_item
);

	localparam int unsigned W  = VALUE_WIDTH;
	localparam int unsigned P  = fau_pkg::WIDE_W;
	localparam int unsigned MP = 2 * VALUE_WIDTH + 2;
	localparam int unsigned CW = $clog2(W + 1);

	logic [2:0]          func_q;
	logic signed [W-1:0] a_q, b_q, c_q, d_q;
	logic signed [P-1:0] p1_q, p2_q;
	logic                err_q;
	logic [W-1:0]        u_q, v_q;
	logic [CW-1:0]       shift_q;
	logic [W-1:0]        g_q;
	logic [W-1:0]        rem_q, quo_q, dvd_q;
	logic [CW-1:0]       cnt_q;
	logic [W-1:0]        qnum_q;
	logic                div_pass_q;
	logic [P-1:0]        rn_q, rd_q;
	logic [1:0]          ord_q;

	// operand slices
	logic signed [W-1:0] a_in, b_in, c_in, d_in;
	assign a_in = in_item.num_a[W-1:0];
	assign b_in = in_item.den_a[W-1:0];
	assign c_in = in_item.num_b[W-1:0];
	assign d_in = in_item.den_b[W-1:0];

	// magnitudes as W-bit unsigned (most negative maps to 2^(W-1))
	logic [W-1:0] mag_a, mag_b;
	assign mag_a = a_q[W-1] ? W'(-a_q) : a_q;
	assign mag_b = b_q[W-1] ? W'(-b_q) : b_q;

	// signs normalised for compare, widened by one bit
	logic signed [W:0] an_n, cn_n, ad_n, cd_n;
	assign an_n = b_q[W-1] ? -(W+1)'(a_q) : (W+1)'(a_q);
	assign ad_n = b_q[W-1] ? -(W+1)'(b_q) : (W+1)'(b_q);
	assign cn_n = d_q[W-1] ? -(W+1)'(c_q) : (W+1)'(c_q);
	assign cd_n = d_q[W-1] ? -(W+1)'(d_q) : (W+1)'(d_q);

	// one multiplier shared over the steps
	logic signed [W:0]    mx, my;
	logic signed [MP-1:0] mprod;
	always_comb begin
		case (func_q)
			fau_pkg::FUNC_CMP: begin
				mx = cmd.mul1 ? an_n : cn_n;
				my = cmd.mul1 ? cd_n : ad_n;
			end
			fau_pkg::FUNC_MUL: begin
				mx = cmd.mul1 ? (W+1)'(a_q) : (W+1)'(b_q);
				my = cmd.mul1 ? (W+1)'(c_q) : (W+1)'(d_q);
			end
			default: begin
				// add: a*d, then c*b, then b*d in the finish step
				mx = cmd.mul1 ? (W+1)'(a_q) : (cmd.mul2 ? (W+1)'(c_q) : (W+1)'(b_q));
				my = cmd.mul1 ? (W+1)'(d_q) : (cmd.mul2 ? (W+1)'(b_q) : (W+1)'(d_q));
			end
		endcase
		mprod = mx * my;
	end

	// gcd step
	logic [W-1:0] v_odd, gu, gv, vdiff;
	always_comb begin
		v_odd = v_q;
		if (!v_q[0]) v_odd = v_q >> 1;
		gu = u_q;
		gv = v_q;
		vdiff = v_q;
		if (v_q[0]) begin
			if (u_q > v_q) begin gu = v_q; gv = u_q - v_q; end
			else           begin gv = v_q - u_q; end
		end else begin
			gv = v_odd;
		end
		vdiff = gv;
	end

	// restoring division, one bit a cycle
	logic [W:0]   trial;
	logic [W-1:0] rem_sh, qfinal;
	logic         last_bit;
	assign rem_sh   = {rem_q[W-2:0], dvd_q[W-1]};
	assign trial    = {1'b0, rem_sh} - {1'b0, g_q};
	assign last_bit = (cnt_q == CW'(W - 1));
	assign qfinal   = trial[W] ? {quo_q[W-2:0], 1'b0} : {quo_q[W-2:0], 1'b1};

	logic err_in;
	always_comb begin
		case (in_item.func) inside
			fau_pkg::FUNC_ADD, fau_pkg::FUNC_MUL, fau_pkg::FUNC_CMP:
				err_in = (b_in == '0) || (d_in == '0);
			fau_pkg::FUNC_REDUCE: err_in = (b_in == '0);
			fau_pkg::FUNC_INVERT: err_in = (b_in == '0) || (a_in == '0);
			default:              err_in = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= in_item.func;
			a_q <= a_in; b_q <= b_in; c_q <= c_in; d_q <= d_in;
			err_q <= err_in;
		end
		if (cmd.mul1) p1_q <= P'(mprod);
		if (cmd.mul2) p2_q <= P'(mprod);
		if (cmd.gcd_pre) begin
			u_q <= mag_a; v_q <= mag_b; shift_q <= '0;
			// gcd(0, n) = n
			g_q <= (mag_a == '0) ? mag_b : mag_a;
		end
		if (cmd.gcd_shift) begin
			u_q <= u_q >> 1; v_q <= v_q >> 1; shift_q <= shift_q + 1'b1;
		end
		if (cmd.gcd_oddu) u_q <= u_q >> 1;
		if (cmd.gcd_loop) begin
			u_q <= gu; v_q <= vdiff;
			if (vdiff == '0) g_q <= gu << shift_q;
		end
	end

	// two division passes: numerator, then denominator
	always_ff @(posedge clk) begin
		if (cmd.div_start_num) begin
			dvd_q <= mag_a; rem_q <= '0; quo_q <= '0; cnt_q <= '0;
			div_pass_q <= 1'b0;
		end
		if (cmd.div_step) begin
			if (last_bit && !div_pass_q) begin
				qnum_q     <= qfinal;
				div_pass_q <= 1'b1;
				dvd_q <= mag_b; rem_q <= '0; quo_q <= '0; cnt_q <= '0;
			end else begin
				dvd_q <= dvd_q << 1;
				cnt_q <= cnt_q + 1'b1;
				quo_q <= qfinal;
				rem_q <= trial[W] ? rem_sh : trial[W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			rn_q <= '0; rd_q <= '0; ord_q <= 2'b00;
			if (!err_q) begin
				case (func_q)
					fau_pkg::FUNC_ADD: begin rn_q <= p1_q + p2_q; rd_q <= P'(mprod); end
					fau_pkg::FUNC_MUL: begin rn_q <= p1_q; rd_q <= p2_q; end
					fau_pkg::FUNC_CMP: begin
						if (p1_q > p2_q)      ord_q <= 2'b01;
						else if (p1_q < p2_q) ord_q <= 2'b11;
					end
					fau_pkg::FUNC_REDUCE: begin
						rn_q <= a_q[W-1] ? -P'(qnum_q) : P'(qnum_q);
						rd_q <= b_q[W-1] ? -P'(quo_q) : P'(quo_q);
					end
					fau_pkg::FUNC_INVERT: begin
						rn_q <= P'(b_q); rd_q <= P'(a_q);
					end
					default: ;
				endcase
			end
		end
	end

	assign stat.func        = func_q;
	assign stat.err         = err_q;
	assign stat.gcd_trivial = (mag_a == '0) || (mag_b == '0);
	assign stat.both_even   = !u_q[0] && !v_q[0];
	assign stat.u_even      = !u_q[0];
	assign stat.v_zero_next = (vdiff == '0) && v_q[0];
	assign stat.div_last    = last_bit && div_pass_q;

	always_comb begin
		out_item.res_num = rn_q;
		out_item.res_den = rd_q;
		out_item.order   = ord_q;
		out_item.status  = err_q;
	end

endmodule

FILE: sv/fraction_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// fraction_arithmetic_unit
// signed fraction add, multiply, compare, gcd reduce and invert
// ----------------------------------------------------------------------------
// add, multiply, compare, invert, unused codes and items with an error run the multiply
// steps, finish and done; reduce runs the multiply steps and gcd setup, then, unless the
// numerator is zero, the gcd shift, odd-u and loop steps, then the numerator and denominator divisions
// throughput: one item at a time, next start taken the cycle after done
// done is a single-cycle strobe; the receiver cannot stall
// arst_n clears the controller only, datapath registers need no reset
module fraction_arithmetic_unit #(
	parameter int unsigned VALUE_WIDTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  fau_pkg::fau_in_t  operands,
	output logic              busy,
	output logic              done,
	output fau_pkg::fau_out_t result
);

	fau_pkg::fau_cmd_t  cmd;
	fau_pkg::fau_stat_t stat;

	// sequencer
	fau_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// arithmetic and gcd datapath
	fau_dp #(.VALUE_WIDTH(VALUE_WIDTH)) u_dp (
		.clk      (clk),
		.in_item  (operands),
		.cmd      (cmd),
		.stat     (stat),
		.out_item (result)
	);

	// result valid in the cycle after finish
	assign done = cmd.done;

	// done only while busy
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n) done |-> busy)
		else $error("done without busy");
	// start while idle always raises busy
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("start not taken");
	// done returns to idle
	a_idle: assert property (@(posedge clk) disable iff (!arst_n) done |=> !busy)
		else $error("not idle after done");

endmodule
